// ===== rtl/core/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer core and checker.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int BYTE_W   = 8;   // output word and symbol width
  localparam int LEN_W    = 6;   // code length field width
  localparam int CODE_W   = 32;  // code bits field width
  localparam int CNT_W    = 3;   // pending bit count width
  localparam int PEND_W   = 7;   // pending bits, fewer than one byte
  localparam int ACC_W    = 40;  // pending + longest code + pad, byte aligned
  localparam int TOP_W    = 6;   // bit count held in the packer, up to ACC_W
  localparam int OP_W     = 2;
  localparam int IN_DATA_W = 48; // symbol, code_length, code_bits, zero fill

  localparam logic [BYTE_W-1:0] EOS_RESET = 8'd3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

// ===== rtl/core/huffman_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Looks up per-symbol prefix codes in a 256-entry table and packs them
// MSB-first into bytes; a finish appends the end marker code and pads.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: symbol, code_length,
//           |     |                             |   code_bits; tuser: op
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: out_byte; tlast: last;
//           |     |                             |   tuser: end_of_stream
//  cfg      | in  | cfg_valid/cfg_ready         | cfg_data: end_marker_symbol
//
// An item of zero or one byte does not hold the input; one of n bytes (up to 5)
// holds it until the output register sends its last byte, at one byte per
// cycle while m_axis is not stalled. A byte passes the lookup stage, packer and
// output register. Reset clears every table length through per-entry valid bits
// at once; no clearing pass. A stall on m_axis holds the packer, then the input.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis_tdata: [7:0] symbol, [13:8] code_length, [45:14] code_bits, zero fill
  input  logic [hcbp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: [1:0] op
  input  logic [hcbp_pkg::OP_W-1:0]          s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // m_axis_tdata: [7:0] out_byte
  output logic [hcbp_pkg::BYTE_W-1:0]        m_axis_tdata,
  // m_axis_tuser: [0] end_of_stream
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [hcbp_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready
);

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

  localparam int BW = hcbp_pkg::BYTE_W;
  localparam int LW = hcbp_pkg::LEN_W;
  localparam int CW = hcbp_pkg::CODE_W;
  localparam int AW = hcbp_pkg::ACC_W;
  localparam int TW = hcbp_pkg::TOP_W;
  localparam int NW = hcbp_pkg::CNT_W;
  localparam int PW = hcbp_pkg::PEND_W;

  // input fields
  logic [BW-1:0]            in_symbol;
  logic [LW-1:0]            in_len;
  logic [CW-1:0]            in_code;
  logic                     in_accept;
  logic                     in_lookup;
  logic                     in_load;
  logic                     in_finish;

  // configuration
  logic [BW-1:0]            end_marker;

  // table
  hcbp_pkg::entry_t         table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]  entry_valid;
  logic [BW-1:0]            rd_symbol;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_in_range;
  logic                     wr_in_range;
  logic [LW-1:0]            len_sat;
  logic [CW-1:0]            code_masked;

  // lookup stage
  logic                     s1_valid;
  logic                     s1_finish;
  logic                     s1_hit;
  hcbp_pkg::entry_t         s1_entry;
  logic [LW-1:0]            s1_len;
  logic [CW-1:0]            s1_code;
  logic                     s1_ready;

  // packer
  logic [PW-1:0]            pend;
  logic [NW-1:0]            pend_cnt;
  logic [AW-1:0]            pk_acc;
  logic [TW-1:0]            pk_top;
  logic                     pk_finish;
  logic                     pk_load;
  logic                     emit;
  logic [TW-1:0]            top_m8;

  logic [AW-1:0]            acc_raw;
  logic [AW-1:0]            acc_pad;
  logic [TW-1:0]            total;
  logic [NW-1:0]            pad;
  logic [TW-1:0]            top_new;
  logic [BW-1:0]            pmask;
  logic [PW-1:0]            pend_next;
  logic [NW-1:0]            pend_cnt_next;

  // output register
  logic                     out_valid;
  logic [BW-1:0]            out_byte;
  logic                     out_last;
  logic                     out_eos;

  assign in_symbol = s_axis_tdata[BW-1:0];
  assign in_len    = s_axis_tdata[BW+LW-1:BW];
  assign in_code   = s_axis_tdata[BW+LW+CW-1:BW+LW];

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_load   = (s_axis_tuser == hcbp_pkg::OP_LOAD);
  assign in_finish = (s_axis_tuser == hcbp_pkg::OP_FINISH);
  assign in_lookup = (s_axis_tuser == hcbp_pkg::OP_ENCODE) || in_finish;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= hcbp_pkg::EOS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      end_marker <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- table
  assign rd_symbol   = in_finish ? end_marker : in_symbol;
  assign rd_addr     = rd_symbol[ADDR_W-1:0];
  assign rd_in_range = ({1'b0, rd_symbol} < (BW+1)'(SYMBOL_COUNT));
  assign wr_in_range = ({1'b0, in_symbol} < (BW+1)'(SYMBOL_COUNT));

  assign len_sat     = (in_len > LW'(LEN_CAP)) ? LW'(LEN_CAP) : in_len;
  assign code_masked = in_code & CW'((33'd1 << len_sat) - 33'd1);

  always_ff @(posedge clk) begin
    if (in_accept && in_load && wr_in_range) begin
      table_mem[in_symbol[ADDR_W-1:0]] <= '{len: len_sat, code: code_masked};
    end
    if (in_accept && in_lookup) begin
      s1_entry <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (in_accept && in_load && wr_in_range) begin
      entry_valid[in_symbol[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // --------------------------------------------------------- lookup stage
  assign s1_ready      = !s1_valid || pk_load;
  assign s_axis_tready = s1_ready && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_accept && in_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_lookup) begin
      s1_finish <= in_finish;
      s1_hit    <= rd_in_range && entry_valid[rd_addr];
    end
  end

  // an unwritten or out-of-range entry reads as an empty code
  assign s1_len  = s1_hit ? s1_entry.len  : '0;
  assign s1_code = s1_hit ? s1_entry.code : '0;

  // --------------------------------------------------------------- packer
  assign emit    = (pk_top >= TW'(BW)) && (!out_valid || m_axis_tready);
  assign top_m8  = pk_top - TW'(BW);
  // take the next item once the packer is empty or sends its final byte
  assign pk_load = s1_valid && ((pk_top < TW'(BW)) || (emit && (pk_top < TW'(2*BW))));

  assign acc_raw = (AW'(pend) << s1_len) | AW'(s1_code);
  assign total   = TW'(pend_cnt) + s1_len;
  assign pad     = s1_finish ? NW'(NW'(0) - total[NW-1:0]) : '0;
  assign acc_pad = acc_raw << pad;
  assign top_new = total + TW'(pad);
  assign pmask   = BW'(BW'(1) << total[NW-1:0]) - BW'(1);

  always_comb begin
    if (s1_finish) begin
      pend_next     = '0;
      pend_cnt_next = '0;
    end else begin
      pend_next     = acc_raw[PW-1:0] & pmask[PW-1:0];
      pend_cnt_next = total[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_top   <= '0;
      pend     <= '0;
      pend_cnt <= '0;
    end else if (pk_load) begin
      pk_top   <= top_new;
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end else if (emit) begin
      pk_top   <= top_m8;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_load) begin
      pk_acc    <= acc_pad;
      pk_finish <= s1_finish;
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= BW'(pk_acc >> top_m8);
      out_last <= (top_m8 < TW'(BW));
      out_eos  <= pk_finish;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_byte;
  assign m_axis_tlast    = out_last;
  assign m_axis_tuser[0] = out_eos;

endmodule

// ===== rtl/core/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the Huffman code bit packer core.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [hcbp_pkg::BYTE_W-1:0]       m_axis_tdata,
  input logic [0:0]                        m_axis_tuser,
  input logic                              m_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);

  logic mid_item;
  logic held_eos;

  // track an item whose bytes are still coming
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_item <= 1'b0;
      held_eos <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mid_item <= !m_axis_tlast;
      held_eos <= m_axis_tuser[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // the pipeline is two deep ahead of the output register
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("output word too soon after reset");

  a_item_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mid_item |-> m_axis_tuser[0] == held_eos)
    else $error("end-of-stream flag changed within one item");

  a_in_drop: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready && !(m_axis_tvalid && !m_axis_tready) |=>
      s_axis_tready || m_axis_tvalid)
    else $error("input stalled with no output pending");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
